/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: field widths,
// stream word layout, opcodes, and the control/status bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

   // field widths
   localparam int KEY_W = 32;
   localparam int PAY_W = 32;
   localparam int CNT_W = 5;

   // stream word widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_W = 72;
   localparam int RSP_W = 72;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture key and payload, start index at the count
      logic rd_top;   // read the entry at count - 1 (smallest key)
      logic rd_next;  // read the entry at index - 2
      logic shift;    // move the read entry up to index, step index down
      logic put;      // write the new entry at index, emit success
      logic take;     // emit the read entry, drop the count
      logic fail;     // emit a rejected result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic idx_one;   // index points just above the bottom entry
      logic less;      // read key is below the held key
      logic out_free;  // result register can take a word this cycle
   } sts_type;

endpackage

/* sv/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, hold data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller of the sorted priority queue: accepts one word at a time and
// sequences the insertion walk, the front removal and the result handoff.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            opcode,
   input  spq_pkg::sts_type sts,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_PUT,
      S_DEL_TAKE,
      S_FAIL
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (opcode == OP_DELETE) begin
                  if (sts.empty) begin
                     state_in = S_FAIL;
                  end else begin
                     cmd.rd_top = 1'b1;
                     state_in   = S_DEL_TAKE;
                  end
               end else begin
                  if (sts.full) begin
                     state_in = S_FAIL;
                  end else if (sts.empty) begin
                     state_in = S_INS_PUT;
                  end else begin
                     cmd.rd_top = 1'b1;
                     state_in   = S_INS_CMP;
                  end
               end
            end
         end
         S_INS_CMP: begin
            // shift smaller entries up until a key at or above the new one
            if (sts.less) begin
               cmd.shift = 1'b1;
               if (sts.idx_one) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            if (sts.out_free) begin
               cmd.put  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DEL_TAKE: begin
            if (sts.out_free) begin
               cmd.take = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FAIL: begin
            if (sts.out_free) begin
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/spq_dpath.sv */
// ----------------------------------------------------------------------------
// spq_dpath
// Datapath of the sorted priority queue: entry RAM kept in descending key
// order (smallest at the top), count and walk index, held input word, and
// the result register.
// ----------------------------------------------------------------------------
module spq_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spq_pkg::cmd_type            cmd,
   output spq_pkg::sts_type            sts,
   input  logic [spq_pkg::KEY_W-1:0]   key_in,
   input  logic [spq_pkg::PAY_W-1:0]   payload_in,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [spq_pkg::RSP_W-1:0]   rsp_tdata
);
   import spq_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int ENT_W  = KEY_W + PAY_W;
   localparam int PAD_W  = RSP_W - (1 + KEY_W + PAY_W + CNT_W);

   logic [IDX_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff;
   logic [PAY_W-1:0]  pay_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   logic [ENT_W-1:0]  rd_data;

   logic              rsp_valid_ff;
   logic              ok_ff;
   logic [KEY_W-1:0]  key_out_ff;
   logic [PAY_W-1:0]  pay_out_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [IDX_W+CNT_W-1:0] occ_ext;
   logic              emit;

   // entry store: key in the low half, payload in the high half
   spq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // write moved entries or the new entry at the walk index
   assign wr_en   = cmd.shift || cmd.put;
   assign wr_addr = idx_ff[ADDR_W-1:0];
   assign wr_data = cmd.shift ? rd_data : {pay_ff, key_ff};

   // read the top entry on accept, then step down during the walk
   assign rd_en  = cmd.rd_top || cmd.rd_next;
   assign rd_idx = cmd.rd_top ? (occ_ff - IDX_W'(1)) : (idx_ff - IDX_W'(2));

   // count and walk index
   always_comb begin
      occ_in = occ_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = occ_ff;
      end else if (cmd.shift) begin
         idx_in = idx_ff - IDX_W'(1);
      end
      if (cmd.put) begin
         occ_in = occ_ff + IDX_W'(1);
      end else if (cmd.take) begin
         occ_in = occ_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         key_ff <= key_in;
         pay_ff <= payload_in;
      end
   end

   // status toward the controller
   assign sts.full     = (occ_ff == IDX_W'(CAPACITY));
   assign sts.empty    = (occ_ff == '0);
   assign sts.idx_one  = (idx_ff == IDX_W'(1));
   assign sts.less     = ($signed(rd_data[KEY_W-1:0]) < $signed(key_ff));
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // result register: count is taken modulo 32
   assign emit    = cmd.put || cmd.take || cmd.fail;
   assign occ_ext = (IDX_W + CNT_W)'(occ_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ok_ff      <= !cmd.fail;
         key_out_ff <= cmd.take ? rd_data[KEY_W-1:0] : '0;
         pay_out_ff <= cmd.take ? rd_data[ENT_W-1:KEY_W] : '0;
         cnt_ff     <= occ_ext[CNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, cnt_ff, pay_out_ff, key_out_ff, ok_ff};

endmodule

/* sv/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded min-priority queue kept in key order; insert and delete-smallest
// words in, one status word out for each.
//
//   channel  dir  tdata fields (lowest bit up)
//   req      in   opcode[0] key_in[32:1] payload_in[64:33] zero pad
//   rsp      out  ok[0] key_out[32:1] payload_out[64:33] entry_count[69:65] pad
//
// A delete reads the top entry on accept and emits it; a rejected word goes
// straight to its result. An insert walks down from the top, shifting up each
// stored key below the new key, and writes the new entry where the walk stops;
// the single RAM write port moves one entry per cycle.
// One word is in flight at a time; the result register lets a word be
// accepted while the previous result waits, and the walk stalls at its end
// until that register frees. Reset empties the queue at once.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // opcode, key_in, payload_in
   input  logic [spq_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // ok, key_out, payload_out, entry_count
   output logic [spq_pkg::RSP_W-1:0] rsp_tdata
);
   import spq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each word
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tdata[0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   // store, walk and result register
   spq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .key_in     (req_tdata[KEY_W:1]),
      .payload_in (req_tdata[KEY_W+PAY_W:KEY_W+1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* bench/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and response streams of the sorted priority queue,
// keeps its own copy of the ordered entry store, predicts the status word of
// every accepted request word and compares each response word against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module spq_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   // opcode, key_in, payload_in
   input  logic [spq_pkg::REQ_W-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // ok, key_out, payload_out, entry_count
   input  logic [spq_pkg::RSP_W-1:0] rsp_tdata,
   output int                        fail_count,
   output int                        pending
);
   import spq_pkg::*;

   // bit offsets of the fields inside the stream words
   localparam int KEY_LO = 1;
   localparam int PAY_LO = KEY_LO + KEY_W;
   localparam int CNT_LO = PAY_LO + PAY_W;

   typedef struct packed {
      logic             ok;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic [CNT_W-1:0] count;
   } status_word_type;

   // shadow copy of the ordered store, smallest key at index 0
   logic signed [KEY_W-1:0] key_mem [CAPACITY];
   logic [PAY_W-1:0]        pay_mem [CAPACITY];
   int unsigned             occupancy = 0;

   status_word_type status_q [$];
   int              mismatches = 0;

   // apply one request word to the shadow store and return its status word
   function automatic status_word_type apply_word(input logic op,
                                                  input logic signed [KEY_W-1:0] key,
                                                  input logic [PAY_W-1:0] pay);
      status_word_type r;
      int unsigned     pos;
      r = '0;
      if (op == OP_INSERT) begin
         if (occupancy < CAPACITY) begin
            // find the first stored key that is not below the new one
            pos = occupancy;
            for (int i = int'(occupancy) - 1; i >= 0; i--) begin
               if (key <= key_mem[i])
                  pos = i;
            end
            for (int i = int'(occupancy); i > int'(pos); i--) begin
               key_mem[i] = key_mem[i-1];
               pay_mem[i] = pay_mem[i-1];
            end
            key_mem[pos] = key;
            pay_mem[pos] = pay;
            occupancy++;
            r.ok = 1'b1;
         end
      end else begin
         if (occupancy > 0) begin
            r.key     = key_mem[0];
            r.payload = pay_mem[0];
            for (int i = 1; i < int'(occupancy); i++) begin
               key_mem[i-1] = key_mem[i];
               pay_mem[i-1] = pay_mem[i];
            end
            occupancy--;
            r.ok = 1'b1;
         end
      end
      r.count = occupancy[CNT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // compare response words first, then queue the prediction of a new request
   always @(posedge clock) begin : watch
      status_word_type got;
      status_word_type want;
      if (reset) begin
         occupancy = 0;
         status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.ok      = rsp_tdata[0];
            got.key     = rsp_tdata[KEY_LO +: KEY_W];
            got.payload = rsp_tdata[PAY_LO +: PAY_W];
            got.count   = rsp_tdata[CNT_LO +: CNT_W];
            if (status_q.size() == 0) begin
               $error("response word %0h with no request waiting", rsp_tdata);
               mismatches++;
            end else begin
               want = status_q.pop_front();
               check_field("ok", 32'(want.ok), 32'(got.ok));
               check_field("key_out", want.key, got.key);
               check_field("payload_out", want.payload, got.payload);
               check_field("entry_count", 32'(want.count), 32'(got.count));
            end
         end
         if (req_tvalid && req_tready)
            status_q.push_back(apply_word(req_tdata[0],
                                          $signed(req_tdata[KEY_LO +: KEY_W]),
                                          req_tdata[PAY_LO +: PAY_W]));
      end
      pending    <= status_q.size();
      fail_count <= mismatches;
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Bench for sorted_priority_queue_unit: a directed run over the key extremes,
// equal keys, an empty delete and a full insert, then random bursts that
// swing the queue between empty and full under random stalls on both
// streams. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import spq_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_WORDS = 1800;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 40;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending;

   bit               sender_quiet;
   int               hold_asks;

   sorted_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   spq_checker #(.CAPACITY(CAPACITY)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one request word, hold it until accepted, then, unless sender_quiet is set, idle for a random gap
   task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                            input logic [PAY_W-1:0] pay);
      int gap;
      req_tdata  <= {{(REQ_W - 1 - KEY_W - PAY_W){1'b0}}, pay, key, op};
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait until every predicted word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // keys that favor duplicates, extremes and the region around zero
   function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] last);
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return $urandom();
      else if (r < 70)
         return ($urandom_range(0, 7) - 3) <<< 16;
      else if (r < 78)
         return 32'h8000_0000 + $urandom_range(0, 3);
      else if (r < 86)
         return 32'h7FFF_FFFF - $urandom_range(0, 3);
      return last;
   endfunction

   // response side: random stalls, quiet stretches, and long holds on request
   initial begin : rsp_side
      int hold;
      int hold_seen;
      bit quiet;
      hold      = 0;
      hold_seen = 0;
      quiet     = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0)
            quiet = !quiet;
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            hold = pick_gap();
            if (hold > 0) begin
               hold--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // end the run when no word moves on either stream for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      int               sent;
      int               burst;
      int               burst_len;
      int               insert_pct;
      logic [KEY_W-1:0] last_key;
      logic [KEY_W-1:0] key;
      logic             op;
      sent         = 0;
      burst        = 0;
      last_key     = '0;
      sender_quiet = 1'b0;
      hold_asks    = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // delete from the empty queue
      send_word(OP_DELETE, $urandom(), $urandom());
      // key extremes, zero, minus one, then two equal keys (newest goes first)
      send_word(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
      send_word(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 32'h0000_0000, 32'h5555_5555);
      send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
      send_word(OP_INSERT, 32'h0001_0000, 32'h0000_00A1);
      send_word(OP_INSERT, 32'h0001_0000, 32'h0000_00B2);
      // fill up with large keys so the front stays known
      repeat (CAPACITY - 6)
         send_word(OP_INSERT, 32'h4000_0000 + $urandom_range(0, 255), $urandom());
      // insert into the full queue
      send_word(OP_INSERT, 32'h8000_0000, 32'hDEAD_BEEF);
      repeat (5)
         send_word(OP_DELETE, $urandom(), $urandom());

      // random bursts with a bias that walks the queue between empty and full
      while (sent < RANDOM_WORDS) begin
         burst_len    = $urandom_range(20, 120);
         if (burst_len > RANDOM_WORDS - sent)
            burst_len = RANDOM_WORDS - sent;
         sender_quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0: insert_pct = 85;
            1: insert_pct = 15;
            2: insert_pct = 50;
            3: insert_pct = 65;
            default: insert_pct = 35;
         endcase
         if (burst == 1 || $urandom_range(0, 9) == 0)
            hold_asks++;
         repeat (burst_len) begin
            op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            key = pick_key(last_key);
            if (op == OP_INSERT)
               last_key = key;
            send_word(op, key, $urandom());
            sent++;
         end
         if (burst == 0 || $urandom_range(0, 3) == 0)
            drain();
         burst++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
